FILE: src/rsr_pkg.sv
// Shared types and constants for the running statistics block.
// Holds operation codes, controller states, and the controller/datapath command
// and status bundles. It depends on nothing else.
package rsr_pkg;

	localparam int RESERVOIR_DEPTH_DEF = 64;
	localparam logic [6:0] CAPACITY_RESET = 7'd64;
	localparam logic [14:0] PCT_FULL = 15'd25600;
	localparam logic CFG_IDX_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		OP_OBSERVE = 2'd0,
		OP_QUERY   = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_UPD, ST_MSTART, ST_MEAN, ST_D2, ST_MUL, ST_MACC,
		ST_M2, ST_VCHK, ST_VAR, ST_RES, ST_SH_INIT, ST_SH_RD, ST_SH_WR,
		ST_INS_RD, ST_INS_CMP, ST_Q_R, ST_Q_START, ST_Q_LOHI, ST_Q_RD_LO,
		ST_Q_RD_HI, ST_Q_DIFF, ST_Q_PROD, ST_Q_FSTART, ST_Q_FIN, ST_CLR,
		ST_DONE, ST_DIV_WAIT
	} state_t;

	typedef enum logic [2:0] {
		DV_MEAN, DV_VAR, DV_MOD, DV_PLO, DV_PFRAC
	} div_sel_t;

	typedef enum logic [1:0] {
		RS_SHIFT, RS_INS, RS_LO, RS_HI
	} rd_sel_t;

	typedef enum logic [1:0] {
		WS_SHIFT, WS_POS_RD, WS_POS_SMP
	} wr_sel_t;

	typedef struct packed {
		logic     load_item;
		logic     upd_stats;
		logic     div_start;
		div_sel_t div_sel;
		logic     mean_upd;
		logic     d2_calc;
		logic     mul_load;
		logic [1:0] mul_part;
		logic     mul_acc;
		logic     m2_upd;
		logic     var_upd;
		logic     var_zero;
		logic     clear_stats;
		logic     ins_init;
		logic     ins_last;
		logic     pos_dec;
		logic     sh_init;
		logic     sh_inc;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     q_r;
		logic     q_lohi;
		logic     q_elo;
		logic     q_diff;
		logic     q_prod;
		logic     q_fin;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cap_zero;
		logic res_full;
		logic pct_ok;
		logic count_ge2;
		logic sh_end;
		logic pos_zero;
		logic rd_gt;
		logic div_done;
	} sts_t;

endpackage

FILE: src/rsr_div.sv
// Dividers of the running statistics block: a shared radix-2 restoring divider for the
// mean step, the variance and the replacement index, and a short reciprocal divider by
// the percentile scale. Depends on nothing else.
module rsr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [31:0] remainder
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_sh;
	logic        ge;

	// One restoring step: shift in the next dividend bit and try a subtract.
	always_comb begin
		rem_sh = {rem_q, quo_q[63]};
		ge = rem_sh >= {1'b0, dvs_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// Division of a 48-bit value by 25600: the low eight bits pass to the remainder and the
// rest is divided by 100 one byte a cycle with a reciprocal multiply (five steps).
module rsr_cdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	output logic        done,
	output logic [39:0] quotient,
	output logic [14:0] remainder
);

	localparam logic [13:0] RECIP_100 = 14'd10486;
	localparam logic [14:0] DIV_100 = 15'd100;

	logic        busy_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [39:0] num_q;
	logic [6:0]  rem_q;
	logic [7:0]  low_q;
	logic [14:0] part;
	logic [28:0] prod;
	logic [7:0]  qd;
	logic [14:0] back;

	// One byte step: the partial value stays below 25600, where the reciprocal is exact.
	always_comb begin
		part = {rem_q, num_q[39:32]};
		prod = {14'd0, part} * {15'd0, RECIP_100};
		qd = prod[27:20];
		back = part - {7'd0, qd} * DIV_100;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bytes shift in as the dividend bytes shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[47:8];
			low_q <= dividend[7:0];
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], qd};
			rem_q <= back[6:0];
		end
	end

	assign done = done_q;
	assign quotient = num_q;
	assign remainder = {rem_q, low_q};

endmodule

FILE: src/rsr_dp.sv
// Datapath of the running statistics block: statistics registers, multiplier,
// reservoir memory, percentile arithmetic and the result register.
// Depends on rsr_pkg, rsr_div and rsr_cdiv.
module rsr_dp
	import rsr_pkg::*;
#(
	parameter int RESERVOIR_DEPTH = RESERVOIR_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         operation,
	input  logic signed [31:0] sample,
	input  logic [15:0]        percentile_point,
	input  logic [6:0]         cap,
	output logic               status,
	output logic [31:0]        sample_count,
	output logic signed [63:0] running_sum,
	output logic signed [31:0] running_mean,
	output logic [62:0]        sample_variance,
	output logic signed [31:0] minimum,
	output logic signed [31:0] maximum,
	output logic signed [31:0] percentile_value,
	output logic               percentile_valid
);

	localparam int AW = $clog2(RESERVOIR_DEPTH);
	localparam int FW = $clog2(RESERVOIR_DEPTH + 1);
	localparam int CW = (FW > 7) ? FW : 7;
	localparam logic [CW-1:0] DEPTH_C = CW'(RESERVOIR_DEPTH);

	// Statistics state.
	logic [31:0]        count_q;
	logic signed [63:0] sum_q;
	logic signed [49:0] mean_q;
	logic [63:0]        m2_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;
	logic [62:0]        var_q;
	logic [FW-1:0]      fill_q;

	// Item and working registers.
	op_t                op_q;
	logic signed [31:0] smp_q;
	logic [15:0]        pt_q;
	logic               sat_q;
	logic signed [49:0] d1_q;
	logic [49:0]        a_q;
	logic [49:0]        b_q;
	logic [49:0]        prod_q;
	logic [1:0]         prod_sh_q;
	logic [99:0]        acc_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      j_q;
	logic [31:0]        r_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [14:0]        frac_q;
	logic signed [31:0] elo_q;
	logic [32:0]        diff_q;
	logic [47:0]        pprod_q;
	logic signed [31:0] pct_q;
	logic               pct_valid_q;
	logic signed [31:0] rd_q;

	logic signed [31:0] mem [RESERVOIR_DEPTH];

	// Combinational helpers.
	logic [FW-1:0]      cap_eff;
	logic [CW-1:0]      cap_w;
	logic signed [49:0] x_w;
	logic signed [49:0] d2_w;
	logic [49:0]        mag_d1;
	logic [49:0]        q50;
	logic signed [64:0] sum65;
	logic [67:0]        hi68;
	logic [64:0]        m2sum;
	logic [14:0]        p_clamp;
	logic [FW:0]        lo1;
	logic [FW-1:0]      lo_w;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               div_start;
	logic [63:0]        div_dvd;
	logic [31:0]        div_dvs;
	logic               div_done;
	logic [63:0]        div_quo;
	logic [31:0]        div_rem;
	logic               cdiv_start;
	logic [47:0]        cdiv_dvd;
	logic               cdiv_done;
	logic [39:0]        cdiv_quo;
	logic [14:0]        cdiv_rem;

	rsr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	rsr_cdiv u_cdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(cdiv_start),
		.dividend(cdiv_dvd),
		.done(cdiv_done),
		.quotient(cdiv_quo),
		.remainder(cdiv_rem)
	);

	// Effective capacity, limited to the reservoir depth.
	always_comb begin
		cap_w = CW'(cap);
		cap_eff = (cap_w > DEPTH_C) ? FW'(DEPTH_C) : FW'(cap_w);
	end

	// Arithmetic helpers for the Welford update and the percentile.
	always_comb begin
		x_w = {{2{smp_q[31]}}, smp_q, 16'h0000};
		d2_w = x_w - mean_q;
		mag_d1 = d1_q[49] ? 50'(-d1_q) : 50'(d1_q);
		q50 = div_quo[49:0];
		sum65 = {sum_q[63], sum_q} + 65'(smp_q);
		hi68 = acc_q[99:32];
		m2sum = {1'b0, m2_q} + {1'b0, hi68[63:0]};
		p_clamp = (pt_q > 16'(PCT_FULL)) ? PCT_FULL : pt_q[14:0];
		lo_w = cdiv_quo[FW-1:0];
		lo1 = {1'b0, lo_w} + (FW+1)'(1);
	end

	// Divider operand selection; divisions by the percentile scale use the short divider.
	always_comb begin
		div_start = 1'b0;
		cdiv_start = 1'b0;
		div_dvd = 64'(mag_d1);
		div_dvs = count_q;
		cdiv_dvd = 48'(r_q);
		unique case (cmd.div_sel)
			DV_MEAN: begin
				div_start = cmd.div_start;
				div_dvd = 64'(mag_d1);
				div_dvs = count_q;
			end
			DV_VAR: begin
				div_start = cmd.div_start;
				div_dvd = m2_q;
				div_dvs = count_q - 32'd1;
			end
			DV_MOD: begin
				div_start = cmd.div_start;
				div_dvd = 64'(count_q);
				div_dvs = 32'(cap_eff);
			end
			DV_PLO: begin
				cdiv_start = cmd.div_start;
				cdiv_dvd = 48'(r_q);
			end
			DV_PFRAC: begin
				cdiv_start = cmd.div_start;
				cdiv_dvd = pprod_q;
			end
			default: begin
				div_start = cmd.div_start;
				div_dvd = 64'(mag_d1);
				div_dvs = count_q;
			end
		endcase
	end

	// Reservoir address and data selection.
	always_comb begin
		unique case (cmd.rd_sel)
			RS_SHIFT: rd_addr = j_q + AW'(1);
			RS_INS:   rd_addr = pos_q - AW'(1);
			RS_LO:    rd_addr = lo_q;
			RS_HI:    rd_addr = hi_q;
			default:  rd_addr = lo_q;
		endcase
		unique case (cmd.wr_sel)
			WS_SHIFT: begin
				wr_addr = j_q;
				wr_data = rd_q;
			end
			WS_POS_RD: begin
				wr_addr = pos_q;
				wr_data = rd_q;
			end
			WS_POS_SMP: begin
				wr_addr = pos_q;
				wr_data = smp_q;
			end
			default: begin
				wr_addr = pos_q;
				wr_data = smp_q;
			end
		endcase
	end

	// Reservoir memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Statistics registers, cleared by reset and by the clear operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			mean_q <= '0;
			m2_q <= '0;
			min_q <= 32'sh7FFFFFFF;
			max_q <= 32'sh80000000;
			var_q <= '0;
			fill_q <= '0;
		end else if (cmd.clear_stats) begin
			count_q <= '0;
			sum_q <= '0;
			mean_q <= '0;
			m2_q <= '0;
			min_q <= 32'sh7FFFFFFF;
			max_q <= 32'sh80000000;
			var_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.upd_stats) begin
				if (count_q != 32'hFFFFFFFF) begin
					count_q <= count_q + 32'd1;
				end
				if (sum65[64] != sum65[63]) begin
					sum_q <= smp_q[31] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
				end else begin
					sum_q <= sum65[63:0];
				end
				if (smp_q < min_q) begin
					min_q <= smp_q;
				end
				if (smp_q > max_q) begin
					max_q <= smp_q;
				end
			end
			if (cmd.mean_upd) begin
				mean_q <= d1_q[49] ? (mean_q - q50) : (mean_q + q50);
			end
			if (cmd.m2_upd) begin
				if ((hi68[67:64] != 4'd0) || m2sum[64]) begin
					m2_q <= 64'hFFFFFFFFFFFFFFFF;
				end else begin
					m2_q <= m2sum[63:0];
				end
			end
			if (cmd.var_upd) begin
				var_q <= div_quo[63] ? 63'h7FFFFFFFFFFFFFFF : div_quo[62:0];
			end else if (cmd.var_zero) begin
				var_q <= '0;
			end
			if (cmd.ins_init) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= op_t'(operation);
			smp_q <= sample;
			pt_q <= percentile_point;
			pct_q <= '0;
			pct_valid_q <= 1'b0;
		end
		if (cmd.load_item) begin
			sat_q <= 1'b0;
		end else if (cmd.upd_stats && (sum65[64] != sum65[63])) begin
			sat_q <= 1'b1;
		end else if (cmd.m2_upd && ((hi68[67:64] != 4'd0) || m2sum[64])) begin
			sat_q <= 1'b1;
		end
		if (cmd.upd_stats) begin
			d1_q <= x_w - mean_q;
		end
		if (cmd.d2_calc) begin
			a_q <= mag_d1;
			b_q <= d2_w[49] ? 50'(-d2_w) : 50'(d2_w);
			acc_q <= '0;
		end
		// Four 25 by 25 bit partial products of the deviation product.
		if (cmd.mul_load) begin
			unique case (cmd.mul_part)
				2'd0: prod_q <= a_q[24:0] * b_q[24:0];
				2'd1: prod_q <= a_q[24:0] * b_q[49:25];
				2'd2: prod_q <= a_q[49:25] * b_q[24:0];
				2'd3: prod_q <= a_q[49:25] * b_q[49:25];
				default: prod_q <= '0;
			endcase
			prod_sh_q <= cmd.mul_part;
		end
		if (cmd.mul_acc) begin
			unique case (prod_sh_q)
				2'd0: acc_q <= acc_q + 100'(prod_q);
				2'd1, 2'd2: acc_q <= acc_q + (100'(prod_q) << 25);
				2'd3: acc_q <= acc_q + (100'(prod_q) << 50);
				default: acc_q <= acc_q;
			endcase
		end
		// Insertion position and shift index.
		if (cmd.ins_init) begin
			pos_q <= AW'(fill_q);
		end else if (cmd.ins_last) begin
			pos_q <= AW'(fill_q - FW'(1));
		end else if (cmd.pos_dec) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.sh_init) begin
			j_q <= div_rem[AW-1:0];
		end else if (cmd.sh_inc) begin
			j_q <= j_q + AW'(1);
		end
		// Percentile interpolation.
		if (cmd.q_r) begin
			r_q <= 32'(p_clamp) * 32'(fill_q - FW'(1));
		end
		if (cmd.q_lohi) begin
			lo_q <= AW'(lo_w);
			frac_q <= cdiv_rem;
			hi_q <= (lo1 >= {1'b0, fill_q}) ? AW'(fill_q - FW'(1)) : AW'(lo1);
		end
		if (cmd.q_elo) begin
			elo_q <= rd_q;
		end
		if (cmd.q_diff) begin
			diff_q <= 33'(rd_q) - 33'(elo_q);
		end
		if (cmd.q_prod) begin
			pprod_q <= diff_q * frac_q;
		end
		if (cmd.q_fin) begin
			pct_q <= elo_q + cdiv_quo[31:0];
			pct_valid_q <= 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= sat_q;
			sample_count <= count_q;
			running_sum <= sum_q;
			running_mean <= (count_q != 32'd0) ? mean_q[47:16] : 32'sd0;
			sample_variance <= var_q;
			minimum <= (count_q != 32'd0) ? min_q : 32'sd0;
			maximum <= (count_q != 32'd0) ? max_q : 32'sd0;
			percentile_value <= pct_q;
			percentile_valid <= pct_valid_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.op = op_q;
		sts.cap_zero = (cap_eff == FW'(0));
		sts.res_full = (fill_q >= cap_eff);
		sts.pct_ok = (cap != 7'd0) && (fill_q != FW'(0));
		sts.count_ge2 = (count_q >= 32'd2);
		sts.sh_end = ({1'b0, FW'(j_q)} + (FW+1)'(1)) >= {1'b0, fill_q};
		sts.pos_zero = (pos_q == AW'(0));
		sts.rd_gt = (rd_q > smp_q);
		sts.div_done = div_done || cdiv_done;
	end

endmodule

FILE: src/rsr_ctrl.sv
// Controller of the running statistics block: sequences the datapath for each
// item and runs both handshakes. Depends on rsr_pkg.
module rsr_ctrl
	import rsr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q;
	state_t     state_n;
	state_t     ret_q;
	state_t     ret_n;
	logic [1:0] mcnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	// State, return point after a division, multiply step and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			mcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.div_start) begin
				ret_q <= ret_n;
			end
			mcnt_q <= (state_q == ST_MUL) ? mcnt_q + 2'd1 : 2'd0;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		ret_n = ret_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_DISP;
			ST_DISP: begin
				unique case (sts.op)
					OP_OBSERVE: state_n = ST_UPD;
					OP_QUERY:   state_n = sts.pct_ok ? ST_Q_R : ST_DONE;
					OP_CLEAR:   state_n = ST_CLR;
					default:    state_n = ST_DONE;
				endcase
			end
			ST_UPD: state_n = ST_MSTART;
			ST_MSTART: begin
				state_n = ST_DIV_WAIT;
				ret_n = ST_MEAN;
			end
			ST_MEAN: state_n = ST_D2;
			ST_D2: state_n = ST_MUL;
			ST_MUL: if (mcnt_q == 2'd3) state_n = ST_MACC;
			ST_MACC: state_n = ST_M2;
			ST_M2: state_n = ST_VCHK;
			ST_VCHK: begin
				if (sts.count_ge2) begin
					state_n = ST_DIV_WAIT;
					ret_n = ST_VAR;
				end else begin
					state_n = ST_RES;
				end
			end
			ST_VAR: state_n = ST_RES;
			ST_RES: begin
				priority if (sts.cap_zero) begin
					state_n = ST_DONE;
				end else if (!sts.res_full) begin
					state_n = ST_INS_RD;
				end else begin
					state_n = ST_DIV_WAIT;
					ret_n = ST_SH_INIT;
				end
			end
			ST_SH_INIT: state_n = ST_SH_RD;
			ST_SH_RD: state_n = sts.sh_end ? ST_INS_RD : ST_SH_WR;
			ST_SH_WR: state_n = ST_SH_RD;
			ST_INS_RD: state_n = sts.pos_zero ? ST_DONE : ST_INS_CMP;
			ST_INS_CMP: state_n = sts.rd_gt ? ST_INS_RD : ST_DONE;
			ST_Q_R: state_n = ST_Q_START;
			ST_Q_START: begin
				state_n = ST_DIV_WAIT;
				ret_n = ST_Q_LOHI;
			end
			ST_Q_LOHI: state_n = ST_Q_RD_LO;
			ST_Q_RD_LO: state_n = ST_Q_RD_HI;
			ST_Q_RD_HI: state_n = ST_Q_DIFF;
			ST_Q_DIFF: state_n = ST_Q_PROD;
			ST_Q_PROD: state_n = ST_Q_FSTART;
			ST_Q_FSTART: begin
				state_n = ST_DIV_WAIT;
				ret_n = ST_Q_FIN;
			end
			ST_Q_FIN: state_n = ST_DONE;
			ST_CLR: state_n = ST_DONE;
			ST_DONE: if (out_free) state_n = ST_IDLE;
			ST_DIV_WAIT: if (sts.div_done) state_n = ret_q;
			default: state_n = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: cmd.load_item = in_valid;
			ST_UPD: cmd.upd_stats = 1'b1;
			ST_MSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DV_MEAN;
			end
			ST_MEAN: cmd.mean_upd = 1'b1;
			ST_D2: cmd.d2_calc = 1'b1;
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				cmd.mul_part = mcnt_q;
				cmd.mul_acc = (mcnt_q != 2'd0);
			end
			ST_MACC: cmd.mul_acc = 1'b1;
			ST_M2: cmd.m2_upd = 1'b1;
			ST_VCHK: begin
				cmd.div_start = sts.count_ge2;
				cmd.div_sel = DV_VAR;
				cmd.var_zero = !sts.count_ge2;
			end
			ST_VAR: cmd.var_upd = 1'b1;
			ST_RES: begin
				cmd.ins_init = !sts.cap_zero && !sts.res_full;
				cmd.div_start = !sts.cap_zero && sts.res_full;
				cmd.div_sel = DV_MOD;
			end
			ST_SH_INIT: cmd.sh_init = 1'b1;
			ST_SH_RD: begin
				cmd.ins_last = sts.sh_end;
				cmd.rd_en = !sts.sh_end;
				cmd.rd_sel = RS_SHIFT;
			end
			ST_SH_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WS_SHIFT;
				cmd.sh_inc = 1'b1;
			end
			ST_INS_RD: begin
				cmd.wr_en = sts.pos_zero;
				cmd.wr_sel = WS_POS_SMP;
				cmd.rd_en = !sts.pos_zero;
				cmd.rd_sel = RS_INS;
			end
			ST_INS_CMP: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = sts.rd_gt ? WS_POS_RD : WS_POS_SMP;
				cmd.pos_dec = sts.rd_gt;
			end
			ST_Q_R: cmd.q_r = 1'b1;
			ST_Q_START: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DV_PLO;
			end
			ST_Q_LOHI: cmd.q_lohi = 1'b1;
			ST_Q_RD_LO: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RS_LO;
			end
			ST_Q_RD_HI: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RS_HI;
				cmd.q_elo = 1'b1;
			end
			ST_Q_DIFF: cmd.q_diff = 1'b1;
			ST_Q_PROD: cmd.q_prod = 1'b1;
			ST_Q_FSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DV_PFRAC;
			end
			ST_Q_FIN: cmd.q_fin = 1'b1;
			ST_CLR: cmd.clear_stats = 1'b1;
			ST_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/running_stats_with_sorted_reservoir.sv
// Top level of the running statistics block with a sorted sample reservoir.
// Depends on rsr_pkg, rsr_ctrl, rsr_dp, rsr_div and rsr_cdiv.
//
// Usage: each input beat (in_valid, not in_stall) carries an operation:
// observe an integer sample (mean kept in Q34.16), query an interpolated
// percentile, or clear. Every beat yields exactly one output beat with
// count, sum, mean, sample variance, minimum, maximum and, for a query,
// the percentile. One item is worked at a time; in_stall is high from
// acceptance until the controller is back in idle. The work on an item is
// set by the shared one-bit-a-cycle divider and the reservoir walk: an
// observe runs a mean division, a variance division from the second sample
// on and an insertion walk over the moved entries, and with a full reservoir
// another division for the replacement slot plus a shift walk; a query runs
// two divisions by the percentile scale on the short divider. The result
// register lets the next item be accepted while a result waits. While
// out_stall is high a finished item holds in the controller until the
// result register frees. Reset clears the statistics, empties the reservoir
// and sets the capacity register to 64; the reservoir needs no clearing pass.
// The capacity register is written over the APB port at byte address 0.
module running_stats_with_sorted_reservoir
	import rsr_pkg::*;
#(
	parameter int RESERVOIR_DEPTH = RESERVOIR_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] sample,
	input  logic [15:0]        percentile_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [31:0]        sample_count,
	output logic signed [63:0] running_sum,
	output logic signed [31:0] running_mean,
	output logic [62:0]        sample_variance,
	output logic signed [31:0] minimum,
	output logic signed [31:0] maximum,
	output logic signed [31:0] percentile_value,
	output logic               percentile_valid
);

	logic [6:0] cap_q;
	cmd_t       cmd;
	sts_t       sts;

	// Capacity register on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CAPACITY)) begin
			cap_q <= pwdata[6:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? {25'd0, cap_q} : 32'd0;

	rsr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts(sts),
		.cmd(cmd)
	);

	rsr_dp #(
		.RESERVOIR_DEPTH(RESERVOIR_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.operation(operation),
		.sample(sample),
		.percentile_point(percentile_point),
		.cap(cap_q),
		.status(status),
		.sample_count(sample_count),
		.running_sum(running_sum),
		.running_mean(running_mean),
		.sample_variance(sample_variance),
		.minimum(minimum),
		.maximum(maximum),
		.percentile_value(percentile_value),
		.percentile_valid(percentile_valid)
	);

endmodule
